FILE: src/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants for the ray against axis-aligned box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

	// Default coordinate width and fixed point fraction bits.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;

	// Three axes, two slab planes per axis.
	localparam int AXES  = 3;
	localparam int LANES = 2 * AXES;

	// Stages outside the divider: operand prep, then four resolve stages.
	localparam int PREP_STAGES    = 1;
	localparam int RESOLVE_STAGES = 4;

endpackage

`default_nettype wire

FILE: src/rbsi_prep.sv
// ----------------------------------------------------------------------------
// rbsi_prep
// First stage: slab distances, their magnitudes and signs, divisor magnitudes
// and the per-axis test for a zero direction component, with the origin outside its slab.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_prep #(
	parameter int W = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic signed [W-1:0]         origin [rbsi_pkg::AXES],
	input  logic signed [W-1:0]         dir    [rbsi_pkg::AXES],
	input  logic signed [W-1:0]         bmin   [rbsi_pkg::AXES],
	input  logic signed [W-1:0]         bmax   [rbsi_pkg::AXES],
	output logic        [W-1:0]         nm_s1  [rbsi_pkg::LANES],
	output logic        [W-1:0]         dm_s1  [rbsi_pkg::LANES],
	output logic [rbsi_pkg::LANES-1:0]  neg_s1,
	output logic [rbsi_pkg::AXES-1:0]   dz_s1,
	output logic [rbsi_pkg::AXES-1:0]   amiss_s1
);
	import rbsi_pkg::*;

	logic [W-1:0]      nm_c [LANES];
	logic [W-1:0]      dm_c [LANES];
	logic [LANES-1:0]  neg_c;
	logic [AXES-1:0]   dz_c;
	logic [AXES-1:0]   amiss_c;

	always_comb begin
		logic signed [W-1:0] corner;
		logic        [W:0]   diff;
		logic        [W:0]   ndiff;
		logic        [W-1:0] dmag;
		logic                dneg;
		logic                nneg;
		for (int a = 0; a < AXES; a++) begin
			dz_c[a]    = (dir[a] == '0);
			amiss_c[a] = dz_c[a] && ((origin[a] < bmin[a]) || (bmax[a] < origin[a]));
			dneg       = dir[a][W-1];
			dmag       = dneg ? (~dir[a] + 1'b1) : dir[a];
			for (int c = 0; c < 2; c++) begin
				corner = (c == 1) ? bmax[a] : bmin[a];
				diff   = {corner[W-1], corner} - {origin[a][W-1], origin[a]};
				ndiff  = ~diff + 1'b1;
				nneg   = diff[W];
				nm_c[2*a+c]  = nneg ? ndiff[W-1:0] : diff[W-1:0];
				dm_c[2*a+c]  = dmag;
				neg_c[2*a+c] = nneg ^ dneg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nm_s1    <= nm_c;
			dm_s1    <= dm_c;
			neg_s1   <= neg_c;
			dz_s1    <= dz_c;
			amiss_s1 <= amiss_c;
		end
	end

endmodule

`default_nettype wire

FILE: src/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, six lanes, one quotient bit per stage.
// Computes (nm * 2^16) / dm with an overflow flag for quotients of W+ bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_div #(
	parameter int W     = rbsi_pkg::COORD_WIDTH_DEF,
	parameter int TAG_W = 2 * rbsi_pkg::AXES
) (
	input  logic                        clk,
	input  logic [W:0]                  load,
	input  logic [W-1:0]                nm_in  [rbsi_pkg::LANES],
	input  logic [W-1:0]                dm_in  [rbsi_pkg::LANES],
	input  logic [rbsi_pkg::LANES-1:0]  neg_in,
	input  logic [TAG_W-1:0]            tag_in,
	output logic [W-1:0]                q_out  [rbsi_pkg::LANES],
	output logic [rbsi_pkg::LANES-1:0]  ovf_out,
	output logic [rbsi_pkg::LANES-1:0]  neg_out,
	output logic [TAG_W-1:0]            tag_out
);
	import rbsi_pkg::*;

	localparam int DS = W + 1;

	logic [W-1:0]     nm_s  [DS][LANES];
	logic [W-1:0]     dm_s  [DS][LANES];
	logic [W-1:0]     r_s   [DS][LANES];
	logic [W-1:0]     q_s   [DS][LANES];
	logic [LANES-1:0] neg_s [DS];
	logic [LANES-1:0] ovf_s [DS];
	logic [TAG_W-1:0] tag_s [DS];

	genvar k, l;
	generate
		for (k = 0; k < DS; k++) begin : g_stage
			if (k == 0) begin : g_first
				// The quotient exceeds W bits exactly when the top part of the
				// numerator already reaches the divisor.
				always_ff @(posedge clk) begin
					if (load[0]) begin
						for (int i = 0; i < LANES; i++) begin
							nm_s[0][i]     <= nm_in[i];
							dm_s[0][i]     <= dm_in[i];
							r_s[0][i]      <= nm_in[i] >> (W - FRAC_BITS);
							ovf_s[0][i]    <= (nm_in[i] >> (W - FRAC_BITS)) >= dm_in[i];
							q_s[0][i]      <= '0;
						end
						neg_s[0] <= neg_in;
						tag_s[0] <= tag_in;
					end
				end
			end else begin : g_step
				localparam int B = W - k;
				logic [LANES-1:0] nbit;
				logic [W:0]       rsh  [LANES];
				logic [W:0]       rsub [LANES];
				logic [LANES-1:0] ge;

				for (l = 0; l < LANES; l++) begin : g_lane
					if (B >= FRAC_BITS) begin : g_nb
						assign nbit[l] = nm_s[k-1][l][B-FRAC_BITS];
					end else begin : g_zero
						assign nbit[l] = 1'b0;
					end
				end

				always_comb begin
					for (int i = 0; i < LANES; i++) begin
						rsh[i]  = {r_s[k-1][i], nbit[i]};
						rsub[i] = rsh[i] - {1'b0, dm_s[k-1][i]};
						ge[i]   = rsh[i] >= {1'b0, dm_s[k-1][i]};
					end
				end

				always_ff @(posedge clk) begin
					if (load[k]) begin
						for (int i = 0; i < LANES; i++) begin
							nm_s[k][i] <= nm_s[k-1][i];
							dm_s[k][i] <= dm_s[k-1][i];
							r_s[k][i]  <= ge[i] ? rsub[i][W-1:0] : rsh[i][W-1:0];
							q_s[k][i]  <= {q_s[k-1][i][W-2:0], ge[i]};
						end
						ovf_s[k] <= ovf_s[k-1];
						neg_s[k] <= neg_s[k-1];
						tag_s[k] <= tag_s[k-1];
					end
				end
			end
		end
	endgenerate

	assign q_out   = q_s[DS-1];
	assign ovf_out = ovf_s[DS-1];
	assign neg_out = neg_s[DS-1];
	assign tag_out = tag_s[DS-1];

endmodule

`default_nettype wire

FILE: src/rbsi_resolve.sv
// ----------------------------------------------------------------------------
// rbsi_resolve
// Saturates and signs the quotients, orders each slab, reduces to entry and
// exit, and forms the hit flag and hit distance.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_resolve #(
	parameter int W = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic [3:0]                  load,
	input  logic [W-1:0]                q     [rbsi_pkg::LANES],
	input  logic [rbsi_pkg::LANES-1:0]  ovf,
	input  logic [rbsi_pkg::LANES-1:0]  neg,
	input  logic [rbsi_pkg::AXES-1:0]   dz,
	input  logic [rbsi_pkg::AXES-1:0]   amiss,
	output logic                        hit_s4,
	output logic signed [W-1:0]         dist_s4
);
	import rbsi_pkg::*;

	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0] t_s1  [LANES];
	logic [AXES-1:0]     dz_s1;
	logic [AXES-1:0]     amiss_s1;
	logic signed [W-1:0] lo_s2 [AXES];
	logic signed [W-1:0] hi_s2 [AXES];
	logic                miss_s2;
	logic signed [W-1:0] near_s3;
	logic signed [W-1:0] far_s3;
	logic                miss_s3;

	// Stage one: clamp the magnitude, then apply the sign.
	logic [W-1:0] t_c [LANES];
	always_comb begin
		logic [W-1:0] lim;
		logic [W-1:0] mag;
		for (int i = 0; i < LANES; i++) begin
			lim    = neg[i] ? MINV : MAXV;
			mag    = (ovf[i] || (q[i] > lim)) ? lim : q[i];
			t_c[i] = neg[i] ? (~mag + 1'b1) : mag;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			for (int i = 0; i < LANES; i++) begin
				t_s1[i] <= signed'(t_c[i]);
			end
			dz_s1    <= dz;
			amiss_s1 <= amiss;
		end
	end

	// Stage two: order the two planes of each axis. An axis with no motion
	// places no limit.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int a = 0; a < AXES; a++) begin
				if (dz_s1[a]) begin
					lo_s2[a] <= signed'(MINV);
					hi_s2[a] <= signed'(MAXV);
				end else if (t_s1[2*a+1] < t_s1[2*a]) begin
					lo_s2[a] <= t_s1[2*a+1];
					hi_s2[a] <= t_s1[2*a];
				end else begin
					lo_s2[a] <= t_s1[2*a];
					hi_s2[a] <= t_s1[2*a+1];
				end
			end
			miss_s2 <= |amiss_s1;
		end
	end

	// Stage three: entry is the largest lower bound, exit the smallest upper.
	logic signed [W-1:0] near_c;
	logic signed [W-1:0] far_c;
	always_comb begin
		near_c = lo_s2[0];
		far_c  = hi_s2[0];
		for (int a = 1; a < AXES; a++) begin
			if (near_c < lo_s2[a]) begin
				near_c = lo_s2[a];
			end
			if (hi_s2[a] < far_c) begin
				far_c = hi_s2[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			near_s3 <= near_c;
			far_s3  <= far_c;
			miss_s3 <= miss_s2;
		end
	end

	// Stage four: result register.
	logic hit_c;
	assign hit_c = !miss_s3 && !(far_s3 < near_s3) && !far_s3[W-1];

	always_ff @(posedge clk) begin
		if (load[3]) begin
			hit_s4 <= hit_c;
			if (!hit_c) begin
				dist_s4 <= '0;
			end else if (near_s3 > 0) begin
				dist_s4 <= near_s3;
			end else begin
				dist_s4 <= far_s3;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box, slab method, signed fixed point with 16
// fraction bits.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall is low; the pipeline depth
// is set by the six-lane restoring divider, which retires one quotient bit
// per stage.
// Each stage advances into an empty or advancing successor, so bubbles close
// up and a stalled output still lets the input side fill empty stages.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data
// registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect #(
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] hit_distance
);
	import rbsi_pkg::*;

	localparam int W  = COORD_WIDTH;
	// Prep stage, W+1 divider stages, then the resolve stages.
	localparam int DS = W + 1;
	localparam int NS = PREP_STAGES + DS + RESOLVE_STAGES;

	// One valid bit per pipeline stage, and the load enable of each stage.
	// A stage loads when it is empty or when its contents move on.
	logic [NS-1:0] v_q;
	logic [NS-1:0] load;

	always_comb begin
		load[NS-1] = !v_q[NS-1] || !out_stall;
		for (int i = NS - 2; i >= 0; i--) begin
			load[i] = !v_q[i] || load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (load[i]) begin
					v_q[i] <= (i == 0) ? in_valid : v_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign in_stall  = !load[0];
	assign out_valid = v_q[NS-1];

	// Group the coordinates by axis.
	logic signed [W-1:0] origin [AXES];
	logic signed [W-1:0] dir    [AXES];
	logic signed [W-1:0] bmin   [AXES];
	logic signed [W-1:0] bmax   [AXES];

	assign origin = '{origin_x, origin_y, origin_z};
	assign dir    = '{dir_x, dir_y, dir_z};
	assign bmin   = '{box_min_x, box_min_y, box_min_z};
	assign bmax   = '{box_max_x, box_max_y, box_max_z};

	// Stage one: magnitudes and signs of the slab distances and directions.
	logic [W-1:0]     nm_s1 [LANES];
	logic [W-1:0]     dm_s1 [LANES];
	logic [LANES-1:0] neg_s1;
	logic [AXES-1:0]  dz_s1;
	logic [AXES-1:0]  amiss_s1;

	rbsi_prep #(.W(W)) u_prep (
		.clk      (clk),
		.load     (load[0]),
		.origin   (origin),
		.dir      (dir),
		.bmin     (bmin),
		.bmax     (bmax),
		.nm_s1    (nm_s1),
		.dm_s1    (dm_s1),
		.neg_s1   (neg_s1),
		.dz_s1    (dz_s1),
		.amiss_s1 (amiss_s1)
	);

	// Divider: the zero-direction and axis-miss flags ride along as a tag.
	logic [W-1:0]      q_div   [LANES];
	logic [LANES-1:0]  ovf_div;
	logic [LANES-1:0]  neg_div;
	logic [2*AXES-1:0] tag_div;

	rbsi_div #(.W(W), .TAG_W(2 * AXES)) u_div (
		.clk     (clk),
		.load    (load[DS:1]),
		.nm_in   (nm_s1),
		.dm_in   (dm_s1),
		.neg_in  (neg_s1),
		.tag_in  ({amiss_s1, dz_s1}),
		.q_out   (q_div),
		.ovf_out (ovf_div),
		.neg_out (neg_div),
		.tag_out (tag_div)
	);

	// Saturation, slab ordering, entry and exit, and the result register.
	rbsi_resolve #(.W(W)) u_resolve (
		.clk     (clk),
		.load    (load[NS-1:NS-RESOLVE_STAGES]),
		.q       (q_div),
		.ovf     (ovf_div),
		.neg     (neg_div),
		.dz      (tag_div[AXES-1:0]),
		.amiss   (tag_div[2*AXES-1:AXES]),
		.hit_s4  (hit),
		.dist_s4 (hit_distance)
	);

endmodule

`default_nettype wire
